@@ hdl/rsg_pkg.sv @@
// ============================================================================
// rsg_pkg
// Shared widths, register indexes, configuration struct and the constant
// sigmoid table for the radial sigmoid emphasis gain block.
// ============================================================================
package rsg_pkg;

   // Image and table sizing
   localparam int MAX_DIM         = 4096;
   localparam int SIG_TABLE_DEPTH = 512;

   // Field widths
   localparam int COORD_W = $clog2(MAX_DIM);
   localparam int COEF_W  = 32;
   localparam int GAIN_W  = 16;
   localparam int CUT_W   = 13;
   localparam int SIG_W   = 16;

   // Configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_LOW  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_HIGH = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CUTOFF    = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_LOW_RST  = 16'd2048;
   localparam logic [GAIN_W-1:0] GAIN_HIGH_RST = 16'd4915;
   localparam logic [CUT_W-1:0]  CUTOFF_RST    = 13'd70;

   // Radius datapath: root of (x^2 + y^2) << 16 gives 8 fraction bits
   localparam int SQ_W       = 2 * COORD_W;
   localparam int SUM_W      = SQ_W + 1;
   localparam int RAD_SHIFT  = 16;
   localparam int RAD_FRAC   = RAD_SHIFT / 2;
   localparam int RAD_IN_W   = SUM_W + RAD_SHIFT;
   localparam int ROOT_W     = (RAD_IN_W + 1) / 2;
   localparam int REM_W      = RAD_IN_W + 1;

   // Difference to the cutoff, Q8, clamped to [-16, 16)
   localparam int CUT_Q8_W   = CUT_W + RAD_FRAC;
   localparam int D8_W       = ((ROOT_W > CUT_Q8_W) ? ROOT_W : CUT_Q8_W) + 1;
   localparam int DIFF_HALF  = 16 << RAD_FRAC;
   localparam int OFFS_W     = $clog2(2 * DIFF_HALF);
   localparam logic signed [D8_W-1:0] DIFF_MIN = D8_W'(-DIFF_HALF);
   localparam logic signed [D8_W-1:0] DIFF_MAX = D8_W'(DIFF_HALF - 1);

   // Table index
   localparam int IDX_W  = $clog2(SIG_TABLE_DEPTH);
   localparam int IDXP_W = OFFS_W + IDX_W + 1;

   // Gain blend
   localparam int GPROD_W = GAIN_W + SIG_W + 1;
   localparam logic [SIG_W:0] ONE_Q16 = (SIG_W + 1)'(1) << SIG_W;

   // Output scaling: coef * gain in Q.28, back to Q.16
   localparam int GAIN_FRAC = 12;
   localparam int PROD_W    = COEF_W + GAIN_W + 1;
   localparam int Q_W       = PROD_W + 1 - GAIN_FRAC;

   typedef struct packed {
      logic [GAIN_W-1:0] gain_low;
      logic [GAIN_W-1:0] gain_high;
      logic [CUT_W-1:0]  cutoff_radius;
   } cfg_type;

   typedef logic [SIG_W-1:0] sig_table_type [SIG_TABLE_DEPTH];

   // Unsigned floor quotient by shift and subtract, used only at elaboration
   function automatic longint unsigned udiv64(
      input longint unsigned n,
      input longint unsigned d
   );
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], n[b]};
         if (rem >= d) begin
            rem    = rem - d;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Logistic sigmoid at each bin midpoint, unsigned Q0.16, built at
   // elaboration with a Q32 series for exp(-a).
   function automatic sig_table_type build_sig_table();
      sig_table_type     tab;
      longint            m;
      longint            sum;
      longint unsigned   mag;
      longint unsigned   a;
      longint unsigned   whole;
      longint unsigned   frac;
      longint unsigned   term;
      longint unsigned   v;
      longint unsigned   den;
      longint unsigned   s;
      for (int i = 0; i < SIG_TABLE_DEPTH; i++) begin
         m     = 2 * longint'(i) + 1 - longint'(SIG_TABLE_DEPTH);
         mag   = (m < 0) ? longint'(-m) : longint'(m);
         a     = ((mag * 64'd16) << 32) / SIG_TABLE_DEPTH;
         whole = a >> 32;
         frac  = a & 64'hFFFF_FFFF;
         term  = 64'd1 << 32;
         sum   = longint'(term);
         for (int k = 1; k <= 13; k++) begin
            term = udiv64((term * frac) >> 32, longint'(k));
            if (k % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         v = (sum < 0) ? 64'd0 : longint'(sum);
         for (longint unsigned w = 0; w < whole; w++) begin
            v = (v * 64'd1580030169) >> 32;
         end
         den = (64'd1 << 32) + v;
         s   = udiv64((64'd1 << 48) + den / 2, den);
         if (s > 64'd65535) begin
            s = 64'd65535;
         end
         tab[i] = (m < 0) ? SIG_W'(64'd65536 - s) : SIG_W'(s);
      end
      return tab;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

@@ hdl/rsg_radius.sv @@
// ============================================================================
// rsg_radius
// Clamps the coordinates, squares and sums them, then takes the integer
// square root of the sum << 16 one result bit per pipeline stage.
// ============================================================================
module rsg_radius
   import rsg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [COORD_W-1:0]       col_pos,
   input  logic [COORD_W-1:0]       row_pos,
   input  logic signed [COEF_W-1:0] coef_in,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [ROOT_W-1:0]        root,
   output logic signed [COEF_W-1:0] coef_out
);

   // squares, sum, then one stage per root bit
   localparam int NS = ROOT_W + 2;

   logic [NS-1:0]            valid_ff;
   logic [NS-1:0]            valid_in;
   logic [NS:0]              go;
   logic signed [COEF_W-1:0] coef_ff [NS];

   logic [COORD_W-1:0]  x_clamp;
   logic [COORD_W-1:0]  y_clamp;
   logic [SQ_W-1:0]     xsq_ff;
   logic [SQ_W-1:0]     ysq_ff;
   logic [SUM_W-1:0]    sum;
   logic [RAD_IN_W-1:0] rad_ff;
   logic [REM_W-1:0]    rem_ff [ROOT_W];
   logic [REM_W-1:0]    res_ff [ROOT_W];

   // stage advance: a stage loads when empty or when its successor moves
   always_comb begin
      go[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         go[k] = !valid_ff[k] || go[k+1];
      end
   end

   assign valid_in = (go[NS-1:0] & {valid_ff[NS-2:0], in_valid}) |
                     (~go[NS-1:0] & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // coefficient rides along
   for (genvar k = 0; k < NS; k++) begin : g_side
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (go[0]) begin
               coef_ff[0] <= coef_in;
            end
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (go[k]) begin
               coef_ff[k] <= coef_ff[k-1];
            end
         end
      end
   end

   // clamp to image and square
   assign x_clamp = (32'(col_pos) > 32'(MAX_DIM - 1)) ? COORD_W'(MAX_DIM - 1) : col_pos;
   assign y_clamp = (32'(row_pos) > 32'(MAX_DIM - 1)) ? COORD_W'(MAX_DIM - 1) : row_pos;

   always_ff @(posedge clock) begin
      if (go[0]) begin
         xsq_ff <= SQ_W'(x_clamp) * SQ_W'(x_clamp);
         ysq_ff <= SQ_W'(y_clamp) * SQ_W'(y_clamp);
      end
   end

   // sum and scale for 8 fraction bits of root
   assign sum = SUM_W'(xsq_ff) + SUM_W'(ysq_ff);

   always_ff @(posedge clock) begin
      if (go[1]) begin
         rad_ff <= {sum, {RAD_SHIFT{1'b0}}};
      end
   end

   // digit-by-digit square root, one bit per stage
   for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
      localparam logic [REM_W-1:0] BIT_J = REM_W'(1) << (2 * (ROOT_W - 1 - j));

      logic [REM_W-1:0] rem_prev;
      logic [REM_W-1:0] res_prev;
      logic [REM_W-1:0] trial;

      if (j == 0) begin : g_src_first
         assign rem_prev = REM_W'(rad_ff);
         assign res_prev = '0;
      end else begin : g_src_rest
         assign rem_prev = rem_ff[j-1];
         assign res_prev = res_ff[j-1];
      end

      assign trial = res_prev + BIT_J;

      always_ff @(posedge clock) begin
         if (go[j+2]) begin
            if (rem_prev >= trial) begin
               rem_ff[j] <= rem_prev - trial;
               res_ff[j] <= (res_prev >> 1) + BIT_J;
            end else begin
               rem_ff[j] <= rem_prev;
               res_ff[j] <= res_prev >> 1;
            end
         end
      end
   end

   assign in_ready  = go[0];
   assign out_valid = valid_ff[NS-1];
   assign root      = res_ff[ROOT_W-1][ROOT_W-1:0];
   assign coef_out  = coef_ff[NS-1];

endmodule

@@ hdl/rsg_gain.sv @@
// ============================================================================
// rsg_gain
// Radius minus cutoff, clamp and table index, sigmoid lookup, and the blend
// of the low and high gains into one Q4.12 gain.
// ============================================================================
module rsg_gain
   import rsg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [ROOT_W-1:0]        root,
   input  logic signed [COEF_W-1:0] coef_in,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [GAIN_W-1:0]        gain,
   output logic signed [COEF_W-1:0] coef_out
);

   // index, lookup, products, sum
   localparam int NS = 4;

   logic [NS-1:0]            valid_ff;
   logic [NS-1:0]            valid_in;
   logic [NS:0]              go;
   logic signed [COEF_W-1:0] coef_ff [NS];

   logic signed [D8_W-1:0] d8;
   logic [OFFS_W-1:0]      offs;
   logic [IDXP_W-1:0]      idx_prod;
   logic [IDX_W-1:0]       idx_ff;
   logic [SIG_W-1:0]       sig_ff;
   logic [GPROD_W-1:0]     lo_ff;
   logic [GPROD_W-1:0]     hi_ff;
   logic [GPROD_W:0]       gsum;
   logic [GAIN_W-1:0]      gain_ff;

   // stage advance
   always_comb begin
      go[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         go[k] = !valid_ff[k] || go[k+1];
      end
   end

   assign valid_in = (go[NS-1:0] & {valid_ff[NS-2:0], in_valid}) |
                     (~go[NS-1:0] & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_side
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (go[0]) begin
               coef_ff[0] <= coef_in;
            end
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (go[k]) begin
               coef_ff[k] <= coef_ff[k-1];
            end
         end
      end
   end

   // distance from cutoff in Q8, clamped, offset to a bin index
   assign d8 = $signed(D8_W'(root)) - $signed(D8_W'({cfg.cutoff_radius, {RAD_FRAC{1'b0}}}));

   always_comb begin
      if (d8 < DIFF_MIN) begin
         offs = '0;
      end else if (d8 > DIFF_MAX) begin
         offs = '1;
      end else begin
         offs = OFFS_W'(d8 - DIFF_MIN);
      end
   end

   assign idx_prod = IDXP_W'(offs) * IDXP_W'(SIG_TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (go[0]) begin
         idx_ff <= idx_prod[OFFS_W +: IDX_W];
      end
   end

   // sigmoid lookup
   always_ff @(posedge clock) begin
      if (go[1]) begin
         sig_ff <= SIG_TABLE[idx_ff];
      end
   end

   // weighted gains
   always_ff @(posedge clock) begin
      if (go[2]) begin
         lo_ff <= GPROD_W'(cfg.gain_low) * GPROD_W'(ONE_Q16 - (SIG_W + 1)'(sig_ff));
         hi_ff <= GPROD_W'(cfg.gain_high) * GPROD_W'(sig_ff);
      end
   end

   // blend with round half up
   assign gsum = (GPROD_W + 1)'(lo_ff) + (GPROD_W + 1)'(hi_ff) +
                 ((GPROD_W + 1)'(1) << (SIG_W - 1));

   always_ff @(posedge clock) begin
      if (go[3]) begin
         gain_ff <= gsum[SIG_W +: GAIN_W];
      end
   end

   assign in_ready  = go[0];
   assign out_valid = valid_ff[NS-1];
   assign gain      = gain_ff;
   assign coef_out  = coef_ff[NS-1];

endmodule

@@ hdl/rsg_scale.sv @@
// ============================================================================
// rsg_scale
// Multiplies the coefficient by the gain, rounds back to Q15.16 and
// saturates. The last stage is the result register.
// ============================================================================
module rsg_scale
   import rsg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [GAIN_W-1:0]        gain,
   input  logic signed [COEF_W-1:0] coef_in,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [COEF_W-1:0] coef_out,
   output logic                     clipped
);

   localparam int NS = 2;

   localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
   localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W - 1){1'b0}}};

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS:0]   go;

   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W:0]     rnd;
   logic signed [Q_W-1:0]      q;
   logic [Q_W-COEF_W:0]        q_top;
   logic                       ovf;
   logic signed [COEF_W-1:0]   coef_ff;
   logic                       clipped_ff;

   // stage advance
   always_comb begin
      go[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         go[k] = !valid_ff[k] || go[k+1];
      end
   end

   assign valid_in = (go[NS-1:0] & {valid_ff[NS-2:0], in_valid}) |
                     (~go[NS-1:0] & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // coefficient times gain, Q.28
   always_ff @(posedge clock) begin
      if (go[0]) begin
         prod_ff <= PROD_W'(coef_in) * PROD_W'($signed({1'b0, gain}));
      end
   end

   // round half up, floor shift, saturate
   assign rnd   = (PROD_W + 1)'(prod_ff) + (PROD_W + 1)'(1 << (GAIN_FRAC - 1));
   assign q     = rnd[PROD_W:GAIN_FRAC];
   assign q_top = q[Q_W-1:COEF_W-1];
   assign ovf   = !((&q_top) || !(|q_top));

   always_ff @(posedge clock) begin
      if (go[1]) begin
         if (ovf) begin
            coef_ff    <= q[Q_W-1] ? COEF_MIN : COEF_MAX;
            clipped_ff <= 1'b1;
         end else begin
            coef_ff    <= q[COEF_W-1:0];
            clipped_ff <= 1'b0;
         end
      end
   end

   assign in_ready  = go[0];
   assign out_valid = valid_ff[NS-1];
   assign coef_out  = coef_ff;
   assign clipped   = clipped_ff;

endmodule

@@ hdl/radial_sigmoid_emphasis_gain.sv @@
// ============================================================================
// radial_sigmoid_emphasis_gain
// Homomorphic high-emphasis gain, a transform coefficient per unstalled cycle.
// ============================================================================
// Usage:
//   Request channel (req_valid/req_ready) carries a coefficient with its
//   column and row. The response channel (rsp_valid/rsp_ready) returns the
//   coefficient scaled by a radial sigmoid gain, saturated, with a clip flag.
//   The csr_ port writes gain_low (0), gain_high (1) and cutoff_radius (2);
//   other indexes are ignored. Write registers only while the pipe is empty.
// Pipeline:
//   A request passes through the squares and sum registers, 21 square-root
//   stages of one result bit each, 4 gain stages and 2 scaling stages. One
//   transfer per cycle is sustained while rsp_ready is high.
// Reset:
//   Synchronous active-high reset empties the pipe and loads the register
//   defaults 2048, 4915 and 70.
// Stalls:
//   While rsp_ready is low, a full stage holds only if no later stage is
//   empty; gaps still fill, so requests are taken until the pipe is full.
// ============================================================================
module radial_sigmoid_emphasis_gain
   import rsg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [COORD_W-1:0]       req_col_pos,
   input  logic [COORD_W-1:0]       req_row_pos,
   input  logic signed [COEF_W-1:0] req_coef_in,
   // response
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [COEF_W-1:0] rsp_coef_out,
   output logic                     rsp_clipped,
   // register writes
   input  logic                     csr_we,
   input  logic [CSR_ADDR_W-1:0]    csr_addr,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   cfg_type cfg_ff;

   logic                     rad_valid;
   logic                     rad_ready;
   logic [ROOT_W-1:0]        rad_root;
   logic signed [COEF_W-1:0] rad_coef;

   logic                     gain_valid;
   logic                     gain_ready;
   logic [GAIN_W-1:0]        gain_val;
   logic signed [COEF_W-1:0] gain_coef;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_low      <= GAIN_LOW_RST;
         cfg_ff.gain_high     <= GAIN_HIGH_RST;
         cfg_ff.cutoff_radius <= CUTOFF_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_GAIN_LOW:  cfg_ff.gain_low      <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_HIGH: cfg_ff.gain_high     <= csr_wdata[GAIN_W-1:0];
            CSR_CUTOFF:    cfg_ff.cutoff_radius <= csr_wdata[CUT_W-1:0];
            default: ;
         endcase
      end
   end

   // radius
   rsg_radius u_radius (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .col_pos   (req_col_pos),
      .row_pos   (req_row_pos),
      .coef_in   (req_coef_in),
      .out_valid (rad_valid),
      .out_ready (rad_ready),
      .root      (rad_root),
      .coef_out  (rad_coef)
   );

   // gain from radius
   rsg_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (rad_valid),
      .in_ready  (rad_ready),
      .root      (rad_root),
      .coef_in   (rad_coef),
      .out_valid (gain_valid),
      .out_ready (gain_ready),
      .gain      (gain_val),
      .coef_out  (gain_coef)
   );

   // scale and saturate
   rsg_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (gain_valid),
      .in_ready  (gain_ready),
      .gain      (gain_val),
      .coef_in   (gain_coef),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .coef_out  (rsp_coef_out),
      .clipped   (rsp_clipped)
   );

endmodule
